// File: rtl/lic_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Laser interlock package
// Command codes, register indexes, field widths and reset values shared by
// the laser interlock controller.
// ----------------------------------------------------------------------------
package lic_pkg;

    localparam int CmdW   = 3;
    localparam int PowerW = 10;
    localparam int CountW = 16;
    localparam int CmpW   = 16;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 16;

    typedef enum logic [CmdW-1:0] {
        CMD_TICK    = 3'd0,
        CMD_ARM     = 3'd1,
        CMD_DISARM  = 3'd2,
        CMD_SEGMENT = 3'd3,
        CMD_POWER   = 3'd4
    } t_cmd;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_BOOT_LOCKOUT = 3'd0,
        CFG_IDLE_DISARM  = 3'd1,
        CFG_POWER_MIN    = 3'd2,
        CFG_POWER_MAX    = 3'd3,
        CFG_ACTIVE_HIGH  = 3'd4,
        CFG_PWM_PERIOD   = 3'd5,
        CFG_OFF_COMPARE  = 3'd6,
        CFG_COMMISSIONED = 3'd7
    } t_cfg_idx;

    localparam logic [CountW-1:0] BOOT_LOCKOUT_RST = 16'd1000;
    localparam logic [CountW-1:0] IDLE_DISARM_RST  = 16'd5000;
    localparam logic [PowerW-1:0] POWER_MIN_RST    = 10'd0;
    localparam logic [PowerW-1:0] POWER_MAX_RST    = 10'd1000;
    localparam logic [CmpW-1:0]   PWM_PERIOD_RST   = 16'd1000;
    localparam logic [CmpW-1:0]   OFF_COMPARE_RST  = 16'd0;
    localparam logic [PowerW-1:0] DEFAULT_POWER    = 10'd500;
    localparam logic [CountW-1:0] COUNT_MAX        = '1;

    typedef struct packed {
        logic [CmdW-1:0]   command;
        logic              mark_request;
        logic              prep_request;
        logic              motion_idle;
        logic [PowerW-1:0] power_request;
    } t_cmd_beat;

endpackage

// File: rtl/laser_interlock_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Laser interlock controller
// Safety interlock for a laser output: arm and disarm with boot lockout,
// segment relay and PWM control, power range check and idle auto-disarm.
// ----------------------------------------------------------------------------
//  Channel   Signals                           Direction
//  command   i_in_valid / o_in_ready + fields  in
//  result    o_out_valid / i_out_ready + flags out
//  config    i_cfg_we, i_cfg_index, i_cfg_data in (write only)
//
// One beat is taken every cycle unless the result stalls; a beat waits in the
// input register and its result is registered when it moves to the output.
// The state update is a single pass of flag and counter logic.
// Reset is synchronous and returns config registers, state and valid flags to their defaults.
// A stalled result holds the result register, and the input register
// keeps accepting until it also holds a waiting beat.
// ----------------------------------------------------------------------------
module laser_interlock_controller (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [lic_pkg::CmdW-1:0]      i_command,
    input  logic                          i_mark_request,
    input  logic                          i_prep_request,
    input  logic                          i_motion_idle,
    input  logic [lic_pkg::PowerW-1:0]    i_power_request,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_accepted,
    output logic                          o_relay_on,
    output logic                          o_pwm_running,
    output logic [lic_pkg::CmpW-1:0]      o_compare_value,
    output logic                          o_armed_flag,
    output logic                          o_boot_ready_flag,
    output logic                          o_task_started_flag,
    input  logic                          i_cfg_we,
    input  logic [lic_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  logic [lic_pkg::CfgDataW-1:0]  i_cfg_data
);
    import lic_pkg::*;

    logic [CountW-1:0] r_boot_lockout;
    logic [CountW-1:0] r_idle_disarm;
    logic [PowerW-1:0] r_power_min;
    logic [PowerW-1:0] r_power_max;
    logic              r_active_high;
    logic [CmpW-1:0]   r_pwm_period;
    logic [CmpW-1:0]   r_off_compare;
    logic              r_commissioned;

    logic              r_in_valid;
    t_cmd_beat         r_in;

    logic              r_armed,   n_armed;
    logic              r_relay,   n_relay;
    logic              r_marking, n_marking;
    logic              r_task,    n_task;
    logic              r_boot_done, n_boot_done;
    logic [PowerW-1:0] r_power,   n_power;
    logic [CountW-1:0] r_idle_cnt, n_idle_cnt;
    logic [CountW-1:0] r_boot_cnt, n_boot_cnt;
    logic [CmpW-1:0]   r_compare, n_compare;
    logic              n_ok;

    logic              r_out_valid;
    logic              r_out_ok;

    logic              advance;
    logic [CmpW-1:0]   level_compare;
    logic [CmpW-1:0]   req_compare;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_boot_lockout <= BOOT_LOCKOUT_RST;
            r_idle_disarm  <= IDLE_DISARM_RST;
            r_power_min    <= POWER_MIN_RST;
            r_power_max    <= POWER_MAX_RST;
            r_active_high  <= 1'b1;
            r_pwm_period   <= PWM_PERIOD_RST;
            r_off_compare  <= OFF_COMPARE_RST;
            r_commissioned <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_BOOT_LOCKOUT: r_boot_lockout <= i_cfg_data;
                CFG_IDLE_DISARM:  r_idle_disarm  <= i_cfg_data;
                CFG_POWER_MIN:    r_power_min    <= i_cfg_data[PowerW-1:0];
                CFG_POWER_MAX:    r_power_max    <= i_cfg_data[PowerW-1:0];
                CFG_ACTIVE_HIGH:  r_active_high  <= i_cfg_data[0];
                CFG_PWM_PERIOD:   r_pwm_period   <= i_cfg_data;
                CFG_OFF_COMPARE:  r_off_compare  <= i_cfg_data;
                CFG_COMMISSIONED: r_commissioned <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in.command       <= i_command;
            r_in.mark_request  <= i_mark_request;
            r_in.prep_request  <= i_prep_request;
            r_in.motion_idle   <= i_motion_idle;
            r_in.power_request <= i_power_request;
        end
    end

    assign level_compare = r_active_high ? CmpW'(r_power)
                                         : r_pwm_period - CmpW'(r_power);
    assign req_compare   = r_active_high ? CmpW'(r_in.power_request)
                                         : r_pwm_period - CmpW'(r_in.power_request);

    always_comb begin
        n_armed     = r_armed;
        n_relay     = r_relay;
        n_marking   = r_marking;
        n_task      = r_task;
        n_boot_done = r_boot_done;
        n_power     = r_power;
        n_idle_cnt  = r_idle_cnt;
        n_boot_cnt  = r_boot_cnt;
        n_compare   = r_compare;
        n_ok        = 1'b1;
        unique case (t_cmd'(r_in.command))
            CMD_TICK: begin
                if (!r_boot_done) begin
                    if (r_boot_cnt < r_boot_lockout) begin
                        n_boot_cnt = r_boot_cnt + 1'b1;
                    end
                    if (n_boot_cnt >= r_boot_lockout) begin
                        n_boot_done = 1'b1;
                    end
                end
                if (r_armed) begin
                    if (r_task && r_in.motion_idle) begin
                        if (r_idle_cnt != COUNT_MAX) begin
                            n_idle_cnt = r_idle_cnt + 1'b1;
                        end
                        if (n_idle_cnt >= r_idle_disarm) begin
                            n_compare  = r_off_compare;
                            n_marking  = 1'b0;
                            n_relay    = 1'b0;
                            n_armed    = 1'b0;
                            n_task     = 1'b0;
                            n_idle_cnt = '0;
                        end
                    end else begin
                        n_idle_cnt = '0;
                    end
                end
            end
            CMD_ARM: begin
                n_compare = r_off_compare;
                n_marking = 1'b0;
                n_relay   = 1'b0;
                n_task    = 1'b0;
                if (!r_commissioned || !r_boot_done) begin
                    n_armed = 1'b0;
                    n_ok    = 1'b0;
                end else begin
                    n_armed    = 1'b1;
                    n_idle_cnt = '0;
                end
            end
            CMD_DISARM: begin
                n_compare  = r_off_compare;
                n_marking  = 1'b0;
                n_relay    = 1'b0;
                n_armed    = 1'b0;
                n_task     = 1'b0;
                n_idle_cnt = '0;
            end
            CMD_SEGMENT: begin
                if (!r_armed) begin
                    n_compare = r_off_compare;
                    n_marking = 1'b0;
                    n_relay   = 1'b0;
                end else begin
                    n_task     = 1'b1;
                    n_idle_cnt = '0;
                    priority if (r_in.mark_request) begin
                        n_relay   = 1'b1;
                        n_compare = level_compare;
                        n_marking = 1'b1;
                    end else if (r_in.prep_request) begin
                        n_compare = r_off_compare;
                        n_marking = 1'b0;
                        n_relay   = 1'b1;
                    end else begin
                        n_compare = r_off_compare;
                        n_marking = 1'b0;
                        n_relay   = 1'b0;
                    end
                end
            end
            CMD_POWER: begin
                if (r_in.power_request < r_power_min
                        || r_in.power_request > r_power_max) begin
                    n_ok = 1'b0;
                end else begin
                    n_power = r_in.power_request;
                    if (r_marking) begin
                        n_compare = req_compare;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed     <= 1'b0;
            r_relay     <= 1'b0;
            r_marking   <= 1'b0;
            r_task      <= 1'b0;
            r_boot_done <= 1'b0;
            r_power     <= DEFAULT_POWER;
            r_idle_cnt  <= '0;
            r_boot_cnt  <= '0;
            r_compare   <= OFF_COMPARE_RST;
        end else if (advance) begin
            r_armed     <= n_armed;
            r_relay     <= n_relay;
            r_marking   <= n_marking;
            r_task      <= n_task;
            r_boot_done <= n_boot_done;
            r_power     <= n_power;
            r_idle_cnt  <= n_idle_cnt;
            r_boot_cnt  <= n_boot_cnt;
            r_compare   <= n_compare;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_ok <= n_ok;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_accepted          = r_out_ok;
    assign o_relay_on          = r_relay;
    assign o_pwm_running       = r_marking;
    assign o_compare_value     = r_compare;
    assign o_armed_flag        = r_armed;
    assign o_boot_ready_flag   = r_boot_done;
    assign o_task_started_flag = r_task;

    // Marking, the relay and a started task all require the armed state.
    a_marking_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_marking |-> r_armed)
        else $error("PWM marking while disarmed");

    a_relay_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_relay |-> r_armed)
        else $error("relay on while disarmed");

    a_task_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_task |-> r_armed)
        else $error("task started while disarmed");

    a_arm_after_boot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_armed) |-> r_boot_done)
        else $error("armed before boot lockout elapsed");

endmodule
